[hdl/sliding_window_flood_detector_assert.svh]
// Assertion macros for the flood detector checker
`ifndef SLIDING_WINDOW_FLOOD_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_FLOOD_DETECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SWFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/swfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package swfd_pkg;

  localparam int unsigned DEF_WINDOW_DEPTH     = 64;
  localparam int unsigned DEF_TICKS_PER_SECOND = 10000000;

  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned THRESH_W = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

  localparam logic [WIN_W-1:0]    WINDOW_RESET = 16'd1;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic expired;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hdl/swfd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module swfd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/swfd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module swfd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire swfd_pkg::status_t status,
  output swfd_pkg::cmd_t        cmd
);
  import swfd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.count_zero && status.expired) begin
          cmd.pop    = 1'b1;
          state_next = ST_WAIT;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        // new oldest slot is being read
        state_next = ST_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/swfd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module swfd_dp #(
  parameter int unsigned WINDOW_DEPTH     = swfd_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned TICKS_PER_SECOND = swfd_pkg::DEF_TICKS_PER_SECOND
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [swfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [swfd_pkg::STAMP_W-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [swfd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire swfd_pkg::cmd_t                  cmd,
  output swfd_pkg::status_t                    status
);
  import swfd_pkg::*;

  localparam int unsigned AddrW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned CmpW   = (CntW > THRESH_W) ? CntW : THRESH_W;
  localparam int unsigned LimitW = WIN_W + $clog2(TICKS_PER_SECOND + 1);

  localparam logic [LimitW-1:0] TICKS  = LimitW'(TICKS_PER_SECOND);
  localparam logic [CntW-1:0]   DEPTHC = CntW'(WINDOW_DEPTH);
  localparam logic [SumW-1:0]   DEPTHS = SumW'(WINDOW_DEPTH);

  logic [LimitW-1:0]   limit;
  logic [THRESH_W-1:0] threshold;
  logic [STAMP_W-1:0]  now;
  logic [AddrW-1:0]    oldest;
  logic [CntW-1:0]     count;
  logic [STAMP_W-1:0]  rdata;
  logic                out_flood;
  logic [COUNT_W-1:0]  out_count;

  logic [STAMP_W-1:0]  age;
  logic                full;
  logic                limit_zero;
  logic                store;
  logic [SumW-1:0]     slot_sum;
  logic [AddrW-1:0]    wslot;
  logic [AddrW-1:0]    oldest_next;
  logic [CntW-1:0]     count_new;

  // window in ticks, worked out when the register is written
  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LimitW'(WINDOW_RESET) * TICKS;
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: limit     <= LimitW'(cfg_wdata[WIN_W-1:0]) * TICKS;
        CFG_THRESH: threshold <= cfg_wdata[THRESH_W-1:0];
        default:    ;
      endcase
    end
  end

  swfd_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (wslot),
    .wdata (now),
    .raddr (oldest),
    .rdata (rdata)
  );

  assign age        = now - rdata;
  assign full       = (count == DEPTHC);
  assign limit_zero = (limit == '0);
  assign store      = cmd.finish && !full && !limit_zero;
  assign slot_sum   = SumW'(oldest) + SumW'(count);
  assign wslot      = (slot_sum >= DEPTHS) ? AddrW'(slot_sum - DEPTHS) : AddrW'(slot_sum);
  assign oldest_next = (oldest == AddrW'(WINDOW_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign count_new  = store ? count + 1'b1 : count;

  assign status.count_zero = (count == '0);
  assign status.expired    = (age >= STAMP_W'(limit));
  assign status.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (cmd.pop) begin
      oldest <= oldest_next;
      count  <= count - 1'b1;
    end else if (store) begin
      count  <= count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_flood <= full || (CmpW'(count_new) >= CmpW'(threshold));
      out_count <= COUNT_W'(count_new);
    end
  end

  assign m_tdata = {out_count, out_flood};

endmodule
`default_nettype wire

[hdl/sliding_window_flood_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Width  Contents
// s_axis    in   64     event_time
// m_axis    out  8      flood, recent_count
// cfg       in   1+16   register index, write data (no read-back)
//
// Each event passes the idle and check states; every stamp pruned adds a pop
// and a wait state, for the stamp RAM has a single read port (registered read).
// One event is worked at a time; the next is taken while the result waits.
// A stalled result holds the datapath in its compare step until taken.
// Sync reset clears state, counters, config and out valid; the RAM needs none.
module sliding_window_flood_detector #(
  parameter int unsigned WINDOW_DEPTH     = swfd_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned TICKS_PER_SECOND = swfd_pkg::DEF_TICKS_PER_SECOND
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [swfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [swfd_pkg::STAMP_W-1:0]    s_tdata,  // [63:0] event_time
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [swfd_pkg::OUT_DATA_W-1:0] m_tdata   // [0] flood, [7:1] recent_count
);
  import swfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  swfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swfd_dp #(
    .WINDOW_DEPTH     (WINDOW_DEPTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

[hdl/swfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_flood_detector_assert.svh"
module swfd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [swfd_pkg::OUT_DATA_W-1:0] m_tdata
);

  // one word in flight: ready drops straight after an accept
  `SWFD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
  `SWFD_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "result word dropped")
  `SWFD_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
  `SWFD_ASSERT_NOW(a_out_of_reset, $fell(rst), s_tready && !m_tvalid, "not idle after reset")

endmodule

bind sliding_window_flood_detector swfd_checker u_swfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/sliding_window_flood_detector_tb.sv]
`timescale 1ns / 1ps
module sliding_window_flood_detector_tb;
  import swfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic               flood;
    logic [COUNT_W-1:0] recent;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [STAMP_W-1:0]    s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  sliding_window_flood_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // predictor state: circular log of held stamps
  logic [STAMP_W-1:0]  stamp_log [DEF_WINDOW_DEPTH];
  logic [5:0]          log_head;
  logic [COUNT_W-1:0]  log_held;
  logic [WIN_W-1:0]    win_secs;
  logic [THRESH_W-1:0] flood_level;

  verdict_t pending_verdicts [$];
  int       mismatches;
  int       src_gap_pct;
  int       sink_stall_pct;
  int       sink_hold;
  int       quiet_cycles;

  always #6 clk = ~clk;

  function automatic int pick_idle(int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic verdict_t judge_event(logic [STAMP_W-1:0] t);
    logic [STAMP_W-1:0] lim;
    logic [5:0]         slot;
    verdict_t           v;
    lim = 64'(win_secs) * 64'(DEF_TICKS_PER_SECOND);
    while (log_held != 0 && (t - stamp_log[log_head]) >= lim) begin
      log_head = log_head + 6'd1;
      log_held = log_held - 7'd1;
    end
    if (log_held >= DEF_WINDOW_DEPTH) begin
      v.flood = 1'b1;
    end else begin
      if (lim != 0) begin
        slot = log_head + log_held[5:0];
        stamp_log[slot] = t;
        log_held = log_held + 7'd1;
      end
      v.flood = (log_held >= flood_level);
    end
    v.recent = log_held;
    return v;
  endfunction

  task automatic send_event(input logic [STAMP_W-1:0] t);
    int gap;
    gap = pick_idle(src_gap_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_verdicts.push_back(judge_event(t));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [WIN_W-1:0] w, input logic [THRESH_W-1:0] th);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_THRESH;
    cfg_wdata <= CFG_DATA_W'(th);
    @(posedge clk);
    cfg_we      <= 1'b0;
    win_secs    = w;
    flood_level = th;
  endtask

  task automatic test_reset_values();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_event(64'd0);
    send_event(64'd5);
    send_event(64'd9_999_999);
    send_event(64'd10_000_000);
    send_event(64'd10_000_005);
    wait_drained();
  endtask

  task automatic test_special_cases();
    src_gap_pct    = 30;
    sink_stall_pct = 30;
    // zero threshold
    write_cfg(16'd1, 7'd0);
    send_event(64'd20_000_000);
    send_event(64'd20_000_001);
    wait_drained();
    // zero window, with and without zero threshold
    write_cfg(16'd0, 7'd0);
    send_event(64'd30_000_000);
    send_event(64'd30_000_000);
    wait_drained();
    write_cfg(16'd0, 7'd1);
    send_event(64'd30_000_001);
    wait_drained();
    // time extremes and wrap through zero
    write_cfg(16'hFFFF, 7'd64);
    send_event(64'hFFFF_FFFF_FFFF_FFF0);
    send_event(64'hFFFF_FFFF_FFFF_FFFF);
    send_event(64'd0);
    send_event(64'd16);
    wait_drained();
    // time going backwards
    write_cfg(16'd1, 7'd3);
    send_event(64'd1000);
    send_event(64'd500);
    send_event(64'd2000);
    send_event(64'd3000);
    send_event(64'd2500);
    send_event(64'd10_002_000);
    send_event({$urandom, $urandom});
    send_event({$urandom, $urandom});
    wait_drained();
  endtask

  task automatic test_store_full();
    logic [STAMP_W-1:0] t;
    src_gap_pct    = 10;
    sink_stall_pct = 40;
    write_cfg(16'hFFFF, 7'd64);
    t = {$urandom, $urandom};
    for (int i = 0; i < 75; i++) begin
      t = t + 64'($urandom_range(0, 1000));
      send_event(t);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [STAMP_W-1:0] t;
    logic [STAMP_W-1:0] lim;
    logic [STAMP_W-1:0] step_max;
    logic [WIN_W-1:0]   w;
    logic [THRESH_W-1:0] th;
    int r;
    int pause_at;
    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 5))
        0:       w = 16'd0;
        1:       w = 16'd1;
        2:       w = 16'hFFFF;
        3, 4:    w = WIN_W'($urandom_range(1, 8));
        default: w = WIN_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
        0:       th = 7'd0;
        1:       th = 7'd64;
        default: th = THRESH_W'($urandom_range(1, 63));
      endcase
      src_gap_pct    = (ph % 4 == 1) ? 0 : $urandom_range(0, 50);
      sink_stall_pct = (ph % 4 == 2) ? 0 : $urandom_range(0, 50);
      write_cfg(w, th);
      lim      = 64'(w) * 64'(DEF_TICKS_PER_SECOND);
      step_max = (lim == 0) ? 64'd1000 : lim / 64'($urandom_range(4, 100));
      t        = ($urandom_range(0, 3) == 0) ? ~64'($urandom_range(0, 1 << 20))
                                             : {$urandom, $urandom};
      pause_at = $urandom_range(10, 54);
      for (int i = 0; i < 64; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3)      t = {$urandom, $urandom};
        else if (r < 6) t = t - 64'($urandom_range(1, 100000));
        else if (r < 9) t = t + lim + 64'($urandom);
        else            t = t + ({$urandom, $urandom} % (step_max + 64'd1));
        send_event(t);
        if (i == pause_at) wait_drained();
      end
      wait_drained();
    end
  endtask

  // result sink with random back-pressure
  always @(posedge clk) begin
    int n;
    if (sink_hold != 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      n = pick_idle(sink_stall_pct);
      if (n > 0) begin
        m_tready  <= 1'b0;
        sink_hold <= n - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected word: flood=%0b count=%0d", $time, m_tdata[0],
                 m_tdata[7:1]);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.flood !== m_tdata[0]) begin
          $display("%0t: flood mismatch: expected %0b actual %0b", $time, want.flood,
                   m_tdata[0]);
          mismatches++;
        end
        if (want.recent !== m_tdata[7:1]) begin
          $display("%0t: recent_count mismatch: expected %0d actual %0d", $time,
                   want.recent, m_tdata[7:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time,
               pending_verdicts.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_WINDOW;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    sink_hold      = 0;
    quiet_cycles   = 0;
    mismatches     = 0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    log_head       = '0;
    log_held       = '0;
    win_secs       = WINDOW_RESET;
    flood_level    = THRESH_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_special_cases();
    test_store_full();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
